/* design/tdfe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdfe_pkg
// Types, request, status and config codes of the table driven state machine.
// ----------------------------------------------------------------------------
package tdfe_pkg;

    localparam int MAX_STATES      = 16;
    localparam int MAX_TRANSITIONS = 64;
    localparam int GUARD_COUNT     = 8;
    localparam int STATE_W         = 4;
    localparam int EVENT_W         = 8;
    localparam int GUARD_W         = 4;
    localparam int ACTION_W        = 8;
    localparam int INDEX_W         = 6;
    localparam int SCOUNT_W        = 5;
    localparam int TCOUNT_W        = 7;
    localparam int STATUS_W        = 4;

    localparam logic [2:0] REQ_WRITE_TRANS   = 3'd0;
    localparam logic [2:0] REQ_WRITE_ACTIONS = 3'd1;
    localparam logic [2:0] REQ_START         = 3'd2;
    localparam logic [2:0] REQ_DISPATCH      = 3'd3;
    localparam logic [2:0] REQ_RESET         = 3'd4;
    localparam logic [2:0] REQ_QUERY         = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK            = 4'd0;
    localparam logic [STATUS_W-1:0] ST_LIMIT         = 4'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID_STATE = 4'd2;
    localparam logic [STATUS_W-1:0] ST_NO_TRANSITION = 4'd3;
    localparam logic [STATUS_W-1:0] ST_GUARD_REJECT  = 4'd4;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE     = 4'd5;
    localparam logic [STATUS_W-1:0] ST_SHADOWED      = 4'd6;
    localparam logic [STATUS_W-1:0] ST_UNREACHABLE   = 4'd7;
    localparam logic [STATUS_W-1:0] ST_UNINITIALIZED = 4'd8;

    localparam logic [1:0] CFG_STATE_COUNT      = 2'd0;
    localparam logic [1:0] CFG_TRANSITION_COUNT = 2'd1;
    localparam logic [1:0] CFG_INITIAL_STATE    = 2'd2;

    typedef struct packed {
        logic [STATE_W-1:0]  from_state;
        logic [EVENT_W-1:0]  event_id;
        logic [STATE_W-1:0]  to_state;
        logic [GUARD_W-1:0]  guard_select;
        logic [ACTION_W-1:0] action_id;
    } entry_t;

    typedef struct packed {
        logic [ACTION_W-1:0] enter_action;
        logic [ACTION_W-1:0] exit_action;
    } actions_t;

endpackage

/* design/table_driven_fsm_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_driven_fsm_engine
// Programmable state machine: transition table and state actions in memory.
// ----------------------------------------------------------------------------
// Requests enter on the in_valid / in_ready channel, one transaction each, and
// every request gives exactly one result on out_valid / out_ready.
// Configuration (state_count, transition_count, initial_state) is written on
// cfg_we / cfg_index / cfg_data while the engine is idle: a rule for the user,
// unenforced. One request is worked on at a time; in_ready is high while idle.
// Work per request, T = transition_count:
//   table or action write, ignored codes, early rejects: straight to the result
//   reset request: exit action read, then enter action read
//   dispatch and query: up to T table entries, one table entry read per cycle
//   start: a duplicate scan of each entry against the earlier ones, then the
//   reachability search, every step bound by the single table port
// A finished result waits in the output register; a new request is taken
// meanwhile, and the engine holds its next result until the register frees.
// Reset clears the machine to not started, current state 0, configuration to
// its defaults; table and action memories keep undefined contents.
module table_driven_fsm_engine
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [6:0]                      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [2:0]                      req_type,
    input  logic [tdfe_pkg::INDEX_W-1:0]    entry_index,
    input  logic [tdfe_pkg::STATE_W-1:0]    from_state,
    input  logic [tdfe_pkg::EVENT_W-1:0]    event_id,
    input  logic [tdfe_pkg::STATE_W-1:0]    to_state,
    input  logic [tdfe_pkg::GUARD_W-1:0]    guard_select,
    input  logic [tdfe_pkg::ACTION_W-1:0]   action_id,
    input  logic [tdfe_pkg::ACTION_W-1:0]   enter_action,
    input  logic [tdfe_pkg::ACTION_W-1:0]   exit_action,
    input  logic [7:0]                      conditions,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tdfe_pkg::STATUS_W-1:0]   status,
    output logic [tdfe_pkg::STATE_W-1:0]    current_state,
    output logic [tdfe_pkg::STATE_W-1:0]    prev_state,
    output logic [tdfe_pkg::ACTION_W-1:0]   exit_fired,
    output logic [tdfe_pkg::ACTION_W-1:0]   transition_fired,
    output logic [tdfe_pkg::ACTION_W-1:0]   enter_fired,
    output logic                            exists
);
    import tdfe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_VRD,
        S_VCHK,
        S_VIN,
        S_BINIT,
        S_BPOP,
        S_BSCAN,
        S_VEND,
        S_ACT_X,
        S_ACT_N,
        S_ACT_E,
        S_FIN
    } state_t;

    // memories
    entry_t   tbl_mem [MAX_TRANSITIONS];
    actions_t act_mem [MAX_STATES];
    entry_t   tbl_q;
    actions_t act_q;
    logic               tbl_re;
    logic [INDEX_W-1:0] tbl_raddr;
    logic               act_re;
    logic [STATE_W-1:0] act_raddr;
    logic               tbl_we;
    logic               act_we;

    state_t state_reg, state_next;
    logic [STATE_W-1:0]  cur_reg, cur_next;
    logic                started_reg, started_next;
    logic [SCOUNT_W-1:0] sc_reg;
    logic [TCOUNT_W-1:0] tc_reg;
    logic [STATE_W-1:0]  init_reg;

    logic [2:0]          req_reg, req_next;
    logic [EVENT_W-1:0]  ev_reg, ev_next;
    logic [7:0]          cond_reg, cond_next;
    logic [TCOUNT_W-1:0] ic_reg, ic_next;
    logic [TCOUNT_W-1:0] lim_reg, lim_next;
    logic                pend_reg, pend_next;
    logic                flag_reg, flag_next;
    logic [TCOUNT_W-1:0] vi_reg, vi_next;
    entry_t              ti_reg, ti_next;
    logic [STATE_W-1:0]  new_reg, new_next;
    logic [STATE_W-1:0]  prev_reg, prev_next;
    logic                left_reg, left_next;

    logic [MAX_STATES-1:0] reach_reg, reach_next;
    logic [STATE_W-1:0]    q_reg [MAX_STATES];
    logic [STATE_W-1:0]    q_next [MAX_STATES];
    logic [SCOUNT_W-1:0]   head_reg, head_next;
    logic [SCOUNT_W-1:0]   tail_reg, tail_next;
    logic [STATE_W-1:0]    bfrom_reg, bfrom_next;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ACTION_W-1:0] res_exf_reg, res_exf_next;
    logic [ACTION_W-1:0] res_trf_reg, res_trf_next;
    logic [ACTION_W-1:0] res_enf_reg, res_enf_next;
    logic                res_exists_reg, res_exists_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [STATE_W-1:0]  out_cur_reg;
    logic [STATE_W-1:0]  out_prev_reg;
    logic [ACTION_W-1:0] out_exf_reg;
    logic [ACTION_W-1:0] out_trf_reg;
    logic [ACTION_W-1:0] out_enf_reg;
    logic                out_exists_reg;
    logic                out_load;

    logic [STATUS_W-1:0] shape_st;
    logic [STATUS_W-1:0] run_st;
    logic                scanning;
    logic                issue;
    logic                scan_done;
    logic [MAX_STATES-1:0] used_mask;

    function automatic logic guard_pass(input logic [GUARD_W-1:0] sel,
                                        input logic [7:0] cond);
        logic r;
        if (sel == '0)
            r = 1'b1;
        else if (sel > GUARD_W'(GUARD_COUNT))
            r = 1'b0;
        else
            r = cond[3'(sel - 1'b1)];
        return r;
    endfunction

    always_comb
    begin
        if (sc_reg == '0 || sc_reg > SCOUNT_W'(MAX_STATES))
            shape_st = ST_LIMIT;
        else if (tc_reg > TCOUNT_W'(MAX_TRANSITIONS))
            shape_st = ST_LIMIT;
        else if ({1'b0, init_reg} >= sc_reg)
            shape_st = ST_INVALID_STATE;
        else
            shape_st = ST_OK;
    end

    always_comb
    begin
        if (!started_reg)
            run_st = ST_UNINITIALIZED;
        else if (shape_st != ST_OK)
            run_st = shape_st;
        else if ({1'b0, cur_reg} >= sc_reg)
            run_st = ST_INVALID_STATE;
        else
            run_st = ST_OK;
    end

    always_comb
    begin
        for (int k = 0; k < MAX_STATES; k++)
            used_mask[k] = (SCOUNT_W'(k) < sc_reg);
    end

    assign scanning  = (state_reg == S_SCAN) || (state_reg == S_VIN) ||
                       (state_reg == S_BSCAN);
    assign issue     = scanning && (ic_reg < lim_reg);
    assign scan_done = !pend_reg && (ic_reg >= lim_reg);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_FIN) && (!out_valid_reg || out_ready);
    assign tbl_we    = in_valid && in_ready && (req_type == REQ_WRITE_TRANS);
    assign act_we    = in_valid && in_ready && (req_type == REQ_WRITE_ACTIONS);

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        started_next    = started_reg;
        req_next        = req_reg;
        ev_next         = ev_reg;
        cond_next       = cond_reg;
        ic_next         = ic_reg + TCOUNT_W'(issue);
        lim_next        = lim_reg;
        pend_next       = issue;
        flag_next       = flag_reg;
        vi_next         = vi_reg;
        ti_next         = ti_reg;
        new_next        = new_reg;
        prev_next       = prev_reg;
        left_next       = left_reg;
        reach_next      = reach_reg;
        q_next          = q_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        bfrom_next      = bfrom_reg;
        res_status_next = res_status_reg;
        res_exf_next    = res_exf_reg;
        res_trf_next    = res_trf_reg;
        res_enf_next    = res_enf_reg;
        res_exists_next = res_exists_reg;
        tbl_re          = issue;
        tbl_raddr       = ic_reg[INDEX_W-1:0];
        act_re          = 1'b0;
        act_raddr       = cur_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next        = req_type;
                    ev_next         = event_id;
                    cond_next       = conditions;
                    res_status_next = ST_OK;
                    res_exf_next    = '0;
                    res_trf_next    = '0;
                    res_enf_next    = '0;
                    res_exists_next = 1'b0;
                    left_next       = 1'b0;
                    ic_next         = '0;
                    pend_next       = 1'b0;
                    flag_next       = 1'b0;
                    lim_next        = tc_reg;
                    state_next      = S_FIN;
                    case (req_type)
                        REQ_START:
                        begin
                            if (shape_st != ST_OK)
                            begin
                                res_status_next = shape_st;
                                started_next    = 1'b0;
                                cur_next        = '0;
                            end
                            else if (tc_reg == '0)
                                state_next = S_BINIT;
                            else
                            begin
                                vi_next    = '0;
                                state_next = S_VRD;
                            end
                        end
                        REQ_DISPATCH, REQ_QUERY:
                        begin
                            if (run_st != ST_OK)
                                res_status_next = run_st;
                            else
                                state_next = S_SCAN;
                        end
                        REQ_RESET:
                        begin
                            if (run_st != ST_OK)
                                res_status_next = run_st;
                            else
                            begin
                                left_next  = 1'b1;
                                new_next   = init_reg;
                                state_next = S_ACT_X;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (pend_reg && tbl_q.from_state == cur_reg && tbl_q.event_id == ev_reg)
                begin
                    if (req_reg == REQ_QUERY)
                    begin
                        res_exists_next = 1'b1;
                        pend_next       = 1'b0;
                        state_next      = S_FIN;
                    end
                    else if (guard_pass(tbl_q.guard_select, cond_reg))
                    begin
                        pend_next = 1'b0;
                        if ({1'b0, tbl_q.to_state} >= sc_reg)
                        begin
                            res_status_next = ST_INVALID_STATE;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            left_next    = 1'b1;
                            res_trf_next = tbl_q.action_id;
                            new_next     = tbl_q.to_state;
                            state_next   = S_ACT_X;
                        end
                    end
                    else
                        flag_next = 1'b1;
                end
                else if (scan_done)
                begin
                    if (req_reg == REQ_DISPATCH)
                        res_status_next = flag_reg ? ST_GUARD_REJECT : ST_NO_TRANSITION;
                    state_next = S_FIN;
                end
            end

            S_VRD:
            begin
                tbl_re     = 1'b1;
                tbl_raddr  = vi_reg[INDEX_W-1:0];
                state_next = S_VCHK;
            end

            S_VCHK:
            begin
                ti_next   = tbl_q;
                ic_next   = '0;
                pend_next = 1'b0;
                flag_next = 1'b0;
                lim_next  = vi_reg;
                if ({1'b0, tbl_q.from_state} >= sc_reg || {1'b0, tbl_q.to_state} >= sc_reg)
                begin
                    res_status_next = ST_INVALID_STATE;
                    started_next    = 1'b0;
                    cur_next        = '0;
                    state_next      = S_FIN;
                end
                else if (vi_reg == '0)
                begin
                    vi_next    = vi_reg + 1'b1;
                    state_next = (vi_reg + 1'b1 >= tc_reg) ? S_BINIT : S_VRD;
                end
                else
                    state_next = S_VIN;
            end

            // compare entry vi against every earlier entry, in table order
            S_VIN:
            begin
                if (pend_reg && tbl_q.from_state == ti_reg.from_state &&
                    tbl_q.event_id == ti_reg.event_id)
                begin
                    if ((tbl_q.to_state == ti_reg.to_state &&
                         tbl_q.guard_select == ti_reg.guard_select &&
                         tbl_q.action_id == ti_reg.action_id) ||
                        (tbl_q.guard_select == '0 && ti_reg.guard_select == '0))
                    begin
                        res_status_next = ST_DUPLICATE;
                        started_next    = 1'b0;
                        cur_next        = '0;
                        pend_next       = 1'b0;
                        state_next      = S_FIN;
                    end
                    else if (tbl_q.guard_select == '0)
                        flag_next = 1'b1;
                end
                else if (scan_done)
                begin
                    if (flag_reg)
                    begin
                        res_status_next = ST_SHADOWED;
                        started_next    = 1'b0;
                        cur_next        = '0;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        vi_next    = vi_reg + 1'b1;
                        state_next = (vi_reg + 1'b1 >= tc_reg) ? S_BINIT : S_VRD;
                    end
                end
            end

            S_BINIT:
            begin
                reach_next           = '0;
                reach_next[init_reg] = 1'b1;
                q_next[0]            = init_reg;
                head_next            = '0;
                tail_next            = SCOUNT_W'(1);
                state_next           = S_BPOP;
            end

            S_BPOP:
            begin
                ic_next   = '0;
                pend_next = 1'b0;
                lim_next  = tc_reg;
                if (head_reg < tail_reg)
                begin
                    bfrom_next = q_reg[head_reg[STATE_W-1:0]];
                    head_next  = head_reg + 1'b1;
                    state_next = S_BSCAN;
                end
                else
                    state_next = S_VEND;
            end

            S_BSCAN:
            begin
                if (pend_reg && tbl_q.from_state == bfrom_reg && !reach_reg[tbl_q.to_state])
                begin
                    reach_next[tbl_q.to_state] = 1'b1;
                    if (tail_reg < SCOUNT_W'(MAX_STATES))
                    begin
                        q_next[tail_reg[STATE_W-1:0]] = tbl_q.to_state;
                        tail_next = tail_reg + 1'b1;
                    end
                end
                else if (scan_done)
                    state_next = S_BPOP;
            end

            S_VEND:
            begin
                if ((reach_reg | ~used_mask) != '1)
                begin
                    res_status_next = ST_UNREACHABLE;
                    started_next    = 1'b0;
                    cur_next        = '0;
                    state_next      = S_FIN;
                end
                else
                begin
                    started_next = 1'b1;
                    new_next     = init_reg;
                    state_next   = S_ACT_N;
                end
            end

            S_ACT_X:
            begin
                act_re     = 1'b1;
                act_raddr  = cur_reg;
                prev_next  = cur_reg;
                state_next = S_ACT_N;
            end

            S_ACT_N:
            begin
                if (left_reg)
                    res_exf_next = act_q.exit_action;
                act_re     = 1'b1;
                act_raddr  = new_reg;
                state_next = S_ACT_E;
            end

            S_ACT_E:
            begin
                res_enf_next = act_q.enter_action;
                cur_next     = new_reg;
                state_next   = S_FIN;
            end

            S_FIN:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[entry_index] <= '{from_state, event_id, to_state, guard_select, action_id};
        if (tbl_re)
            tbl_q <= tbl_mem[tbl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (act_we)
            act_mem[from_state] <= '{enter_action, exit_action};
        if (act_re)
            act_q <= act_mem[act_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            started_reg   <= 1'b0;
            sc_reg        <= SCOUNT_W'(1);
            tc_reg        <= '0;
            init_reg      <= '0;
            pend_reg      <= 1'b0;
            ic_reg        <= '0;
            lim_reg       <= '0;
            flag_reg      <= 1'b0;
            left_reg      <= 1'b0;
            reach_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            started_reg <= started_next;
            pend_reg    <= pend_next;
            ic_reg      <= ic_next;
            lim_reg     <= lim_next;
            flag_reg    <= flag_next;
            left_reg    <= left_next;
            reach_reg   <= reach_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STATE_COUNT:      sc_reg   <= cfg_data[SCOUNT_W-1:0];
                    CFG_TRANSITION_COUNT: tc_reg   <= cfg_data[TCOUNT_W-1:0];
                    CFG_INITIAL_STATE:    init_reg <= cfg_data[STATE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        ev_reg         <= ev_next;
        cond_reg       <= cond_next;
        vi_reg         <= vi_next;
        ti_reg         <= ti_next;
        new_reg        <= new_next;
        prev_reg       <= prev_next;
        q_reg          <= q_next;
        bfrom_reg      <= bfrom_next;
        res_status_reg <= res_status_next;
        res_exf_reg    <= res_exf_next;
        res_trf_reg    <= res_trf_next;
        res_enf_reg    <= res_enf_next;
        res_exists_reg <= res_exists_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_cur_reg    <= cur_reg;
            out_prev_reg   <= left_reg ? prev_reg : cur_reg;
            out_exf_reg    <= res_exf_reg;
            out_trf_reg    <= res_trf_reg;
            out_enf_reg    <= res_enf_reg;
            out_exists_reg <= res_exists_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = out_status_reg;
    assign current_state    = out_cur_reg;
    assign prev_state       = out_prev_reg;
    assign exit_fired       = out_exf_reg;
    assign transition_fired = out_trf_reg;
    assign enter_fired      = out_enf_reg;
    assign exists           = out_exists_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("engine stayed idle after a request transaction");

    a_stopped_state_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !started_reg |-> (cur_reg == '0))
        else $error("current state not zero while not started");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= SCOUNT_W'(MAX_STATES))
        else $error("visit queue overflow");

    a_pend_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(tbl_re))
        else $error("table data marked pending without a read");

endmodule

/* verif/tb_table_driven_fsm_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_table_driven_fsm_engine
// Self-checking testbench of the table driven state machine engine.
// ----------------------------------------------------------------------------
// Every memory entry is loaded first, so no request reads undefined contents.
// A short directed sequence covers each status code but ST_UNREACHABLE and
// special cases, then random phases reconfigure the engine, load ring-shaped
// tables and start it, followed by dispatch, query, reset, write and noise
// requests. A predictor computes each result at input acceptance; the monitor
// compares every output transaction field by field. Input bursts and output
// stalls are random.
// ----------------------------------------------------------------------------
module tb_table_driven_fsm_engine;
    import tdfe_pkg::*;

    typedef struct {
        logic [2:0]          req;
        logic [INDEX_W-1:0]  idx;
        logic [STATE_W-1:0]  from;
        logic [EVENT_W-1:0]  ev;
        logic [STATE_W-1:0]  to;
        logic [GUARD_W-1:0]  gsel;
        logic [ACTION_W-1:0] act;
        logic [ACTION_W-1:0] ena;
        logic [ACTION_W-1:0] exa;
        logic [7:0]          cond;
    } fsm_req_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [STATE_W-1:0]  cur;
        logic [STATE_W-1:0]  prev;
        logic [ACTION_W-1:0] exf;
        logic [ACTION_W-1:0] trf;
        logic [ACTION_W-1:0] enf;
        logic                exists;
    } fsm_resp_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [6:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [2:0] req_type;
    logic [INDEX_W-1:0] entry_index;
    logic [STATE_W-1:0] from_state;
    logic [EVENT_W-1:0] event_id;
    logic [STATE_W-1:0] to_state;
    logic [GUARD_W-1:0] guard_select;
    logic [ACTION_W-1:0] action_id;
    logic [ACTION_W-1:0] enter_action;
    logic [ACTION_W-1:0] exit_action;
    logic [7:0] conditions;
    logic out_valid;
    logic out_ready;
    logic [STATUS_W-1:0] status;
    logic [STATE_W-1:0] current_state;
    logic [STATE_W-1:0] prev_state;
    logic [ACTION_W-1:0] exit_fired;
    logic [ACTION_W-1:0] transition_fired;
    logic [ACTION_W-1:0] enter_fired;
    logic exists;

    table_driven_fsm_engine dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .entry_index(entry_index), .from_state(from_state),
        .event_id(event_id), .to_state(to_state), .guard_select(guard_select),
        .action_id(action_id), .enter_action(enter_action),
        .exit_action(exit_action), .conditions(conditions),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .current_state(current_state), .prev_state(prev_state),
        .exit_fired(exit_fired), .transition_fired(transition_fired),
        .enter_fired(enter_fired), .exists(exists)
    );

    // engine image
    entry_t              mdl_table [MAX_TRANSITIONS];
    logic [ACTION_W-1:0] mdl_enter [MAX_STATES];
    logic [ACTION_W-1:0] mdl_exit  [MAX_STATES];
    int                  mdl_cur;
    bit                  mdl_started;
    int                  mdl_scount;
    int                  mdl_tcount;
    int                  mdl_init;

    fsm_req_t  pending_reqs [$];
    fsm_resp_t expected_resps [$];
    fsm_req_t  cur_req;
    int        errors;
    int        n_checked;
    int        n_dispatch_ok;
    int        n_starts_ok;
    int        n_items;
    int        burst_left;
    int        gap_left;
    int        stall_mode;
    int        stall_left;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #40000000;
        $display("timeout at %0t", $time);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [STATUS_W-1:0] shape_status();
        if (mdl_scount < 1 || mdl_scount > MAX_STATES) return ST_LIMIT;
        if (mdl_tcount > MAX_TRANSITIONS) return ST_LIMIT;
        if (mdl_init >= mdl_scount) return ST_INVALID_STATE;
        return ST_OK;
    endfunction

    function automatic logic [STATUS_W-1:0] validate_table();
        logic [STATUS_W-1:0] s;
        bit unguarded;
        bit [MAX_STATES-1:0] reached;
        int visit [MAX_STATES];
        int head;
        int tail;
        int src;
        entry_t t;
        entry_t o;
        s = shape_status();
        if (s != ST_OK) return s;
        for (int i = 0; i < mdl_tcount; i++)
        begin
            t = mdl_table[i];
            unguarded = 0;
            if (t.from_state >= mdl_scount || t.to_state >= mdl_scount)
                return ST_INVALID_STATE;
            for (int j = 0; j < i; j++)
            begin
                o = mdl_table[j];
                if (o.from_state != t.from_state || o.event_id != t.event_id) continue;
                if (o.to_state == t.to_state && o.guard_select == t.guard_select &&
                    o.action_id == t.action_id)
                    return ST_DUPLICATE;
                if (o.guard_select == 0)
                begin
                    unguarded = 1;
                    if (t.guard_select == 0) return ST_DUPLICATE;
                end
            end
            if (unguarded) return ST_SHADOWED;
        end
        reached = '0;
        head = 0;
        tail = 1;
        visit[0] = mdl_init;
        reached[mdl_init] = 1'b1;
        while (head < tail && head < MAX_STATES)
        begin
            src = visit[head];
            head++;
            for (int i = 0; i < mdl_tcount; i++)
            begin
                if (mdl_table[i].from_state != src || reached[mdl_table[i].to_state])
                    continue;
                reached[mdl_table[i].to_state] = 1'b1;
                if (tail < MAX_STATES)
                begin
                    visit[tail] = mdl_table[i].to_state;
                    tail++;
                end
            end
        end
        for (int i = 0; i < mdl_scount; i++)
            if (!reached[i]) return ST_UNREACHABLE;
        return ST_OK;
    endfunction

    function automatic logic [STATUS_W-1:0] running_status();
        logic [STATUS_W-1:0] s;
        if (!mdl_started) return ST_UNINITIALIZED;
        s = shape_status();
        if (s != ST_OK) return s;
        if (mdl_cur >= mdl_scount) return ST_INVALID_STATE;
        return ST_OK;
    endfunction

    function automatic bit guard_ok(logic [GUARD_W-1:0] sel, logic [7:0] cond);
        if (sel == 0) return 1;
        if (sel > GUARD_COUNT) return 0;
        return cond[3'(sel - 1'b1)];
    endfunction

    // advances the engine image by one request and queues its result
    task automatic predict_engine(input fsm_req_t r);
        fsm_resp_t e;
        bit left;
        bit rejected;
        int hit;
        e = '{default: '0};
        left = 0;
        e.prev = STATE_W'(mdl_cur);
        case (r.req)
            REQ_WRITE_TRANS:
                mdl_table[r.idx] = '{r.from, r.ev, r.to, r.gsel, r.act};
            REQ_WRITE_ACTIONS:
            begin
                mdl_enter[r.from] = r.ena;
                mdl_exit[r.from] = r.exa;
            end
            REQ_START:
            begin
                e.status = validate_table();
                if (e.status != ST_OK)
                begin
                    mdl_started = 0;
                    mdl_cur = 0;
                end
                else
                begin
                    mdl_started = 1;
                    mdl_cur = mdl_init;
                    e.enf = mdl_enter[mdl_init];
                    n_starts_ok++;
                end
            end
            REQ_DISPATCH:
            begin
                e.status = running_status();
                if (e.status == ST_OK)
                begin
                    rejected = 0;
                    hit = -1;
                    for (int i = 0; i < mdl_tcount; i++)
                    begin
                        if (mdl_table[i].from_state != mdl_cur || mdl_table[i].event_id != r.ev)
                            continue;
                        if (!guard_ok(mdl_table[i].guard_select, r.cond))
                        begin
                            rejected = 1;
                            continue;
                        end
                        hit = i;
                        break;
                    end
                    if (hit < 0)
                        e.status = rejected ? ST_GUARD_REJECT : ST_NO_TRANSITION;
                    else if (mdl_table[hit].to_state >= mdl_scount)
                        e.status = ST_INVALID_STATE;
                    else
                    begin
                        left = 1;
                        e.exf = mdl_exit[mdl_cur];
                        e.trf = mdl_table[hit].action_id;
                        mdl_cur = int'(mdl_table[hit].to_state);
                        e.enf = mdl_enter[mdl_cur];
                        n_dispatch_ok++;
                    end
                end
            end
            REQ_RESET:
            begin
                e.status = running_status();
                if (e.status == ST_OK)
                begin
                    left = 1;
                    e.exf = mdl_exit[mdl_cur];
                    mdl_cur = mdl_init;
                    e.enf = mdl_enter[mdl_cur];
                end
            end
            REQ_QUERY:
            begin
                e.status = running_status();
                if (e.status == ST_OK)
                    for (int i = 0; i < mdl_tcount; i++)
                        if (mdl_table[i].from_state == mdl_cur && mdl_table[i].event_id == r.ev)
                        begin
                            e.exists = 1'b1;
                            break;
                        end
            end
            default: ;
        endcase
        e.cur = STATE_W'(mdl_cur);
        if (!left) e.prev = STATE_W'(mdl_cur);
        expected_resps.push_back(e);
    endtask

    // driver: bursts of transactions separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid) predict_engine(cur_req);
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                cur_req = pending_reqs.pop_front();
                req_type <= cur_req.req;
                entry_index <= cur_req.idx;
                from_state <= cur_req.from;
                event_id <= cur_req.ev;
                to_state <= cur_req.to;
                guard_select <= cur_req.gsel;
                action_id <= cur_req.act;
                enter_action <= cur_req.ena;
                exit_action <= cur_req.exa;
                conditions <= cur_req.cond;
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: receiver stalls in modes of random length
    always @(posedge clk or negedge rst_n)
    begin
        fsm_resp_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_mode <= 0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_resps.size() == 0)
                begin
                    $display("%0t: unexpected result transaction, status %0d", $time, status);
                    errors++;
                end
                else
                begin
                    e = expected_resps.pop_front();
                    n_checked++;
                    if (status !== e.status || current_state !== e.cur ||
                        prev_state !== e.prev || exit_fired !== e.exf ||
                        transition_fired !== e.trf || enter_fired !== e.enf ||
                        exists !== e.exists)
                    begin
                        $display("%0t: expected st=%0d cur=%0d prev=%0d ex=%0d tr=%0d en=%0d q=%0d",
                                 $time, e.status, e.cur, e.prev, e.exf, e.trf, e.enf,
                                 e.exists);
                        $display("%0t: actual   st=%0d cur=%0d prev=%0d ex=%0d tr=%0d en=%0d q=%0d",
                                 $time, status, current_state, prev_state, exit_fired,
                                 transition_fired, enter_fired, exists);
                        errors++;
                    end
                end
            end
            if (stall_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                stall_left <= $urandom_range(1, 40);
            end
            else
                stall_left <= stall_left - 1;
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic fsm_req_t rand_req(input logic [2:0] req);
        fsm_req_t r;
        r.req = req;
        r.idx = INDEX_W'($urandom);
        r.from = STATE_W'($urandom);
        r.ev = EVENT_W'($urandom);
        r.to = STATE_W'($urandom);
        r.gsel = GUARD_W'($urandom);
        r.act = ACTION_W'($urandom);
        r.ena = ACTION_W'($urandom);
        r.exa = ACTION_W'($urandom);
        r.cond = 8'($urandom);
        return r;
    endfunction

    task automatic send(input fsm_req_t r);
        pending_reqs.push_back(r);
        n_items++;
    endtask

    task automatic send_entry(input int idx, input int from, input int ev, input int to,
                              input int gsel, input int act);
        fsm_req_t r;
        r = rand_req(REQ_WRITE_TRANS);
        r.idx = INDEX_W'(idx);
        r.from = STATE_W'(from);
        r.ev = EVENT_W'(ev);
        r.to = STATE_W'(to);
        r.gsel = GUARD_W'(gsel);
        r.act = ACTION_W'(act);
        send(r);
    endtask

    task automatic send_event(input logic [2:0] req, input int ev, input int cond);
        fsm_req_t r;
        r = rand_req(req);
        r.ev = EVENT_W'(ev);
        r.cond = 8'(cond);
        send(r);
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (!(pending_reqs.size() == 0 && !in_valid && expected_resps.size() == 0));
        repeat (4) @(negedge clk);
    endtask

    task automatic write_config(input int sc, input int tc, input int init);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_STATE_COUNT;
        cfg_data <= sc[6:0];
        mdl_scount = sc & 31;
        @(posedge clk);
        cfg_index <= CFG_TRANSITION_COUNT;
        cfg_data <= tc[6:0];
        mdl_tcount = tc & 127;
        @(posedge clk);
        cfg_index <= CFG_INITIAL_STATE;
        cfg_data <= init[6:0];
        mdl_init = init & 15;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int sc;
        int tc;
        int init;
        int nops;
        int pick;
        fsm_req_t r;
        errors = 0;
        n_checked = 0;
        n_dispatch_ok = 0;
        n_starts_ok = 0;
        n_items = 0;
        mdl_cur = 0;
        mdl_started = 0;
        mdl_scount = 1;
        mdl_tcount = 0;
        mdl_init = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_type = '0;
        entry_index = '0;
        from_state = '0;
        event_id = '0;
        to_state = '0;
        guard_select = '0;
        action_id = '0;
        enter_action = '0;
        exit_action = '0;
        conditions = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // not started answers, then load every memory entry
        send_event(REQ_DISPATCH, 0, 0);
        send_event(REQ_QUERY, 0, 0);
        send_event(REQ_RESET, 0, 0);
        for (int i = 0; i < MAX_TRANSITIONS; i++)
            send_entry(i, $urandom_range(0, 15), $urandom, $urandom_range(0, 15),
                       $urandom_range(0, 15), $urandom);
        for (int s = 0; s < MAX_STATES; s++)
        begin
            r = rand_req(REQ_WRITE_ACTIONS);
            r.from = STATE_W'(s);
            send(r);
        end
        wait_idle();

        // directed: three state ring with guards
        write_config(3, 3, 0);
        send_entry(0, 0, 5, 1, 0, 8'hff);
        send_entry(1, 1, 5, 2, 1, 8'h00);
        send_entry(2, 2, 7, 0, 9, 8'h11);
        send_event(REQ_START, 0, 0);
        send_event(REQ_DISPATCH, 5, 0);
        send_event(REQ_DISPATCH, 5, 8'hfe);
        send_event(REQ_DISPATCH, 5, 8'h01);
        send_event(REQ_DISPATCH, 7, 8'hff);
        send_event(REQ_DISPATCH, 99, 0);
        send_event(REQ_QUERY, 7, 0);
        send_event(REQ_QUERY, 255, 0);
        send_event(REQ_RESET, 0, 0);
        send_event(3'd6, 0, 0);
        send_event(3'd7, 0, 0);
        send_entry(2, 0, 5, 1, 0, 8'hff);
        send_event(REQ_START, 0, 0);
        send_entry(2, 0, 5, 2, 1, 8'h00);
        send_event(REQ_START, 0, 0);
        send_entry(2, 2, 7, 3, 0, 8'h00);
        send_event(REQ_START, 0, 0);
        send_entry(2, 1, 7, 1, 0, 8'h00);
        send_event(REQ_START, 0, 0);
        send_entry(2, 2, 7, 0, 0, 8'h22);
        send_event(REQ_START, 0, 0);
        wait_idle();
        // shrinking while started: destination out of range, then limits
        write_config(2, 3, 0);
        send_event(REQ_DISPATCH, 5, 0);
        send_event(REQ_DISPATCH, 5, 1);
        wait_idle();
        write_config(0, 3, 0);
        send_event(REQ_DISPATCH, 5, 0);
        send_event(REQ_START, 0, 0);
        wait_idle();
        write_config(31, 127, 15);
        send_event(REQ_START, 0, 0);
        wait_idle();

        // random phases
        while (n_items < 700)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0) sc = 16;
            else if (pick == 1) sc = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
            else sc = $urandom_range(1, 8);
            tc = (sc >= 1 && sc <= 16) ? sc + $urandom_range(0, 6) : $urandom_range(0, 8);
            if (tc > MAX_TRANSITIONS) tc = MAX_TRANSITIONS;
            pick = $urandom_range(0, 29);
            if (pick == 0) tc = MAX_TRANSITIONS;
            else if (pick == 1) tc = $urandom_range(65, 127);
            else if (pick == 2) tc = 0;
            init = (sc >= 1 && sc <= 16 && $urandom_range(0, 9) != 0) ?
                   $urandom_range(0, sc - 1) : $urandom_range(0, 15);
            write_config(sc, tc, init);
            if (sc < 1) sc = 1;
            if (sc > 16) sc = 16;
            // ring table, distinct (state, event) pairs with occasional corruption
            if ($urandom_range(0, 4) != 0)
            begin
                for (int i = 0; i < tc && i < MAX_TRANSITIONS; i++)
                begin
                    if ($urandom_range(0, 24) == 0)
                        send_entry(i, $urandom_range(0, 15), $urandom_range(0, 3),
                                   $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
                    else
                        send_entry(i, i % sc, (i / sc) * 3, (i + 1) % sc,
                                   ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0,
                                   $urandom);
                end
            end
            if ($urandom_range(0, 5) != 0) send_event(REQ_START, 0, 0);
            nops = $urandom_range(10, 30);
            for (int k = 0; k < nops; k++)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 10)
                    send_event(REQ_DISPATCH, ($urandom_range(0, 7) == 0) ? $urandom :
                               3 * $urandom_range(0, 4), $urandom);
                else if (pick < 13)
                    send_event(REQ_QUERY, ($urandom_range(0, 4) == 0) ? $urandom :
                               3 * $urandom_range(0, 4), 0);
                else if (pick < 15)
                    send_event(REQ_RESET, 0, 0);
                else if (pick == 15)
                    send(rand_req(REQ_WRITE_ACTIONS));
                else if (pick == 16)
                    send(rand_req(REQ_WRITE_TRANS));
                else if (pick == 17)
                    send(rand_req(3'($urandom_range(6, 7))));
                else
                    send_event(REQ_START, 0, 0);
            end
            wait_idle();
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (expected_resps.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_resps.size());
            errors++;
        end
        $display("checked %0d results of %0d requests: %0d good starts, %0d transitions taken",
                 n_checked, n_items, n_starts_ok, n_dispatch_ok);
        $display("errors: %0d", errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* table_driven_fsm_engine.f */
design/tdfe_pkg.sv
design/table_driven_fsm_engine.sv
verif/tb_table_driven_fsm_engine.sv
